[src/rla_pkg.sv]
// ---------------------------------------------------------------------------
// rla_pkg
// Shared constants, types and tables of the rgb to l-alpha-beta converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rla_pkg;

   // output format
   localparam int OUT_FRAC_BITS = 12;
   localparam int OUT_W         = 16;

   // input channels and rgb to lms matrix
   localparam int CH_W   = 8;
   localparam int NUM_CH = 3;
   localparam int COEF_W = 16;
   localparam int LMS_QF = 16;
   localparam int LMS_W  = 24;   // largest row sum times 255 stays below 2^24

   localparam logic [COEF_W-1:0] LMS_COEF [NUM_CH][NUM_CH] = '{
      '{16'd24976, 16'd37899, 16'd2635},
      '{16'd12891, 16'd47474, 16'd5125},
      '{16'd1579,  16'd8441,  16'd55339}
   };

   // black pixel: lms value of zero becomes 2.0
   localparam logic [LMS_W-1:0] LMS_FLOOR = LMS_W'(2) << LMS_QF;

   // log2 by table lookup and linear interpolation
   localparam int P_W       = $clog2(LMS_W);
   localparam int IDX_W     = 6;
   localparam int ROM_DEPTH = (1 << IDX_W) + 1;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int ROM_W     = LMS_QF + 1;
   localparam int FRAC_W    = 16;
   localparam int E_W       = P_W + 1;
   localparam int L2_W      = E_W + LMS_QF;

   // log10(2) scaling
   localparam int                LOG10_2_FRAC = 24;
   localparam logic [LOG10_2_FRAC-2:0] LOG10_2_Q24 = 23'd5050445;
   localparam int MUL_W    = L2_W + LOG10_2_FRAC;
   localparam int LG_SHIFT = LOG10_2_FRAC + LMS_QF - OUT_FRAC_BITS;
   localparam int LG_W     = OUT_FRAC_BITS + 4;

   // decorrelation matrix, alpha row uses 2 * 26755 for the s term
   localparam logic [COEF_W-1:0] DEC_L_COEF = 16'd37837;
   localparam logic [COEF_W-1:0] DEC_A_COEF = 16'd26755;
   localparam logic [COEF_W-1:0] DEC_B_COEF = 16'd46341;
   localparam int SUM_W  = LG_W + 2;
   localparam int DEC_QF = 16;
   localparam int ACC_W  = SUM_W + COEF_W + 1;
   localparam int RND_W  = ACC_W + 1 - DEC_QF;

   // pipeline stages
   localparam int ST_LMS     = 0;
   localparam int ST_NORM    = 1;
   localparam int ST_LUT     = 2;
   localparam int ST_INTERP  = 3;
   localparam int ST_SCALE   = 4;
   localparam int ST_LOG     = 5;
   localparam int ST_SUM     = 6;
   localparam int ST_MUL     = 7;
   localparam int ST_OUT     = 8;
   localparam int NUM_STAGES = 9;

   typedef logic [NUM_STAGES-1:0]   stage_en_type;
   typedef logic [LMS_W-1:0]        lms_type;
   typedef logic signed [LG_W-1:0]  lg_type;
   typedef logic [ROM_W-1:0]        rom_type [ROM_DEPTH];

   // log2(1 + i/64) in q1.16 by repeated squaring in q1.30
   function automatic rom_type build_log2_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [17:0] acc;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         x   = (64'd1 << 30) + (64'(i) << (30 - IDX_W));
         acc = '0;
         for (int k = 0; k < ROM_W; k++) begin
            x   = (x * x) >> 30;
            acc = acc << 1;
            if (x >= (64'd1 << 31)) begin
               x      = x >> 1;
               acc[0] = 1'b1;
            end
         end
         rom[i] = ROM_W'((acc + 18'd1) >> 1);
      end
      return rom;
   endfunction

   localparam rom_type LOG2_ROM = build_log2_rom();

endpackage

`default_nettype wire

[src/rgb_to_lalphabeta_core.sv]
// ---------------------------------------------------------------------------
// rgb_to_lalphabeta_core
// Pixel-rate conversion of 8-bit rgb to l-alpha-beta, signed q3.12 outputs.
// ---------------------------------------------------------------------------
// usage
//   req channel: one rgb pixel per item, taken when req_valid is high and
//   req_stall is low. rsp channel: one lum/alpha/beta item per pixel, in
//   order, taken when rsp_valid is high and rsp_stall is low.
//   pipeline: 9 register stages: lms matrix 1, log10 5, decorrelation 3.
//   throughput: one pixel per cycle while rsp_stall is low; every stage
//   has its own valid bit and loads whenever it is empty or its successor
//   moves, so bubbles close up.
//   reset: synchronous, clears all valid bits; the pipe is empty and ready
//   on the first cycle after reset. no configuration.
//   receiver stall: the output register holds its item; stages behind it
//   keep filling until all 9 hold an item, then req_stall rises. req_stall
//   is combinational on rsp_stall through the stage valid chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_lalphabeta_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire [rla_pkg::CH_W-1:0]             req_red,
   input  wire [rla_pkg::CH_W-1:0]             req_green,
   input  wire [rla_pkg::CH_W-1:0]             req_blue,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [rla_pkg::OUT_W-1:0]    rsp_lum,
   output logic signed [rla_pkg::OUT_W-1:0]    rsp_alpha,
   output logic signed [rla_pkg::OUT_W-1:0]    rsp_beta
);

   localparam int LAST = rla_pkg::NUM_STAGES - 1;

   rla_pkg::stage_en_type stage_en;
   rla_pkg::stage_en_type v_in;
   rla_pkg::stage_en_type v_ff;
   logic                  in_acc;
   logic                  out_acc;

   rla_pkg::lms_type lms [rla_pkg::NUM_CH];
   rla_pkg::lg_type  lg  [rla_pkg::NUM_CH];

   // a stage loads when it is empty or its item moves on
   always_comb begin
      stage_en[LAST] = !v_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         stage_en[k] = !v_ff[k] || stage_en[k+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      v_in[0] = stage_en[0] ? req_valid : v_ff[0];
      for (int k = 1; k < rla_pkg::NUM_STAGES; k++) begin
         v_in[k] = stage_en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = v_ff[LAST];
   assign in_acc    = req_valid && !req_stall;
   assign out_acc   = rsp_valid && !rsp_stall;

   // rgb to lms
   rla_lms u_lms (
      .clock (clock),
      .adv   (stage_en),
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .lms   (lms)
   );

   // one log10 pipe per lms channel
   for (genvar c = 0; c < rla_pkg::NUM_CH; c++) begin : g_log
      rla_log10 u_log10 (
         .clock (clock),
         .adv   (stage_en),
         .lms   (lms[c]),
         .lg    (lg[c])
      );
   end

   // decorrelation and output register
   rla_decor u_decor (
      .clock (clock),
      .adv   (stage_en),
      .lg    (lg),
      .lum   (rsp_lum),
      .alpha (rsp_alpha),
      .beta  (rsp_beta)
   );

   // items in flight change only by acceptances on the two channels
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(v_ff) == $countones($past(v_ff))
                          + int'($past(in_acc)) - int'($past(out_acc))))
      else $error("pipeline occupancy does not match channel traffic");

   // a stage that is full and cannot move keeps its item
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(v_ff) & ~$past(stage_en) & ~v_ff) == '0))
      else $error("stalled stage dropped its item");

   // a new result only comes from the stage before the output register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid) |-> $past(v_ff[LAST-1]))
      else $error("result appeared without an item behind it");

endmodule

`default_nettype wire

[src/rla_lms.sv]
// ---------------------------------------------------------------------------
// rla_lms
// First pipeline stage: rgb to lms matrix, exact unsigned q8.16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rla_lms (
   input  wire                          clock,
   input  rla_pkg::stage_en_type        adv,
   input  wire [rla_pkg::CH_W-1:0]      red,
   input  wire [rla_pkg::CH_W-1:0]      green,
   input  wire [rla_pkg::CH_W-1:0]      blue,
   output rla_pkg::lms_type             lms [rla_pkg::NUM_CH]
);

   localparam int PAD_C = rla_pkg::LMS_W - rla_pkg::COEF_W;
   localparam int PAD_X = rla_pkg::LMS_W - rla_pkg::CH_W;

   rla_pkg::lms_type lms_in [rla_pkg::NUM_CH];
   rla_pkg::lms_type lms_ff [rla_pkg::NUM_CH];

   always_comb begin
      for (int i = 0; i < rla_pkg::NUM_CH; i++) begin
         lms_in[i] = {{PAD_C{1'b0}}, rla_pkg::LMS_COEF[i][0]} * {{PAD_X{1'b0}}, red}
                   + {{PAD_C{1'b0}}, rla_pkg::LMS_COEF[i][1]} * {{PAD_X{1'b0}}, green}
                   + {{PAD_C{1'b0}}, rla_pkg::LMS_COEF[i][2]} * {{PAD_X{1'b0}}, blue};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[rla_pkg::ST_LMS]) begin
         lms_ff <= lms_in;
      end
   end

   assign lms = lms_ff;

endmodule

`default_nettype wire

[src/rla_log10.sv]
// ---------------------------------------------------------------------------
// rla_log10
// Five-stage log10 of one lms value: normalize, table, interpolate, scale,
// round.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rla_log10 (
   input  wire                    clock,
   input  rla_pkg::stage_en_type  adv,
   input  rla_pkg::lms_type       lms,
   output rla_pkg::lg_type        lg
);

   localparam logic signed [rla_pkg::LOG10_2_FRAC-1:0] LOG_K = {1'b0, rla_pkg::LOG10_2_Q24};
   localparam logic [rla_pkg::MUL_W:0] LG_HALF =
      (rla_pkg::MUL_W + 1)'(1) << (rla_pkg::LG_SHIFT - 1);
   localparam logic [rla_pkg::MUL_W:0] LG_HALF_M1 = LG_HALF - (rla_pkg::MUL_W + 1)'(1);
   localparam int PROD_W = rla_pkg::ROM_W + rla_pkg::FRAC_W;

   // normalize stage
   rla_pkg::lms_type           v_sel;
   logic [rla_pkg::P_W-1:0]    p_in;
   rla_pkg::lms_type           v_ff;
   logic [rla_pkg::P_W-1:0]    p_ff;

   // table stage
   rla_pkg::lms_type              mant;
   logic [rla_pkg::IDX_W-1:0]     idx;
   logic [rla_pkg::ROM_AW-1:0]    addr0;
   logic [rla_pkg::ROM_AW-1:0]    addr1;
   logic [rla_pkg::ROM_W-1:0]     t0;
   logic [rla_pkg::ROM_W-1:0]     t1;
   logic [rla_pkg::ROM_W-1:0]     t0_ff;
   logic [rla_pkg::ROM_W-1:0]     dt_ff;
   logic [rla_pkg::FRAC_W-1:0]    w_ff;
   logic [rla_pkg::P_W-1:0]       pl_ff;

   // interpolation stage
   logic [PROD_W-1:0]             prod;
   logic [rla_pkg::ROM_W-1:0]     fl;
   logic [rla_pkg::E_W-1:0]       expo;
   logic [rla_pkg::L2_W-1:0]      l2_in;
   logic [rla_pkg::L2_W-1:0]      l2_ff;

   // scale and round stages
   logic signed [rla_pkg::MUL_W-1:0] mul_in;
   logic signed [rla_pkg::MUL_W-1:0] mul_ff;
   logic [rla_pkg::MUL_W:0]          rnd;
   rla_pkg::lg_type                  lg_ff;

   // leading one search, black pixel floor
   always_comb begin
      v_sel = (lms == '0) ? rla_pkg::LMS_FLOOR : lms;
      p_in  = '0;
      for (int b = 0; b < rla_pkg::LMS_W; b++) begin
         if (v_sel[b]) begin
            p_in = rla_pkg::P_W'(b);
         end
      end
   end

   // shift top one to the msb, split into table index and weight
   always_comb begin
      mant  = v_ff << (rla_pkg::P_W'(rla_pkg::LMS_W - 1) - p_ff);
      idx   = mant[rla_pkg::LMS_W-2 -: rla_pkg::IDX_W];
      addr0 = {1'b0, idx};
      addr1 = addr0 + rla_pkg::ROM_AW'(1);
      t0    = rla_pkg::LOG2_ROM[addr0];
      t1    = rla_pkg::LOG2_ROM[addr1];
   end

   // fraction plus exponent, q.16
   always_comb begin
      prod  = PROD_W'(dt_ff) * PROD_W'(w_ff);
      fl    = t0_ff + prod[PROD_W-1:rla_pkg::FRAC_W];
      expo  = {1'b0, pl_ff} - rla_pkg::E_W'(rla_pkg::LMS_QF);
      l2_in = {expo, {rla_pkg::LMS_QF{1'b0}}} + rla_pkg::L2_W'(fl);
   end

   assign mul_in = rla_pkg::MUL_W'($signed(l2_ff)) * rla_pkg::MUL_W'(LOG_K);

   // round half away from zero
   assign rnd = {mul_ff[rla_pkg::MUL_W-1], mul_ff}
              + (mul_ff[rla_pkg::MUL_W-1] ? LG_HALF_M1 : LG_HALF);

   always_ff @(posedge clock) begin
      if (adv[rla_pkg::ST_NORM]) begin
         v_ff <= v_sel;
         p_ff <= p_in;
      end
      if (adv[rla_pkg::ST_LUT]) begin
         t0_ff <= t0;
         dt_ff <= t1 - t0;
         w_ff  <= mant[rla_pkg::LMS_W-2-rla_pkg::IDX_W -: rla_pkg::FRAC_W];
         pl_ff <= p_ff;
      end
      if (adv[rla_pkg::ST_INTERP]) begin
         l2_ff <= l2_in;
      end
      if (adv[rla_pkg::ST_SCALE]) begin
         mul_ff <= mul_in;
      end
      if (adv[rla_pkg::ST_LOG]) begin
         lg_ff <= $signed(rnd[rla_pkg::LG_SHIFT +: rla_pkg::LG_W]);
      end
   end

   assign lg = lg_ff;

endmodule

`default_nettype wire

[src/rla_decor.sv]
// ---------------------------------------------------------------------------
// rla_decor
// Three-stage decorrelation of the log values into l, alpha and beta:
// sums, constant products, rounding with saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rla_decor (
   input  wire                                 clock,
   input  rla_pkg::stage_en_type               adv,
   input  rla_pkg::lg_type                     lg [rla_pkg::NUM_CH],
   output logic signed [rla_pkg::OUT_W-1:0]    lum,
   output logic signed [rla_pkg::OUT_W-1:0]    alpha,
   output logic signed [rla_pkg::OUT_W-1:0]    beta
);

   localparam logic signed [rla_pkg::COEF_W:0] K_L = {1'b0, rla_pkg::DEC_L_COEF};
   localparam logic signed [rla_pkg::COEF_W:0] K_A = {1'b0, rla_pkg::DEC_A_COEF};
   localparam logic signed [rla_pkg::COEF_W:0] K_B = {1'b0, rla_pkg::DEC_B_COEF};
   localparam logic [rla_pkg::ACC_W:0] HALF =
      (rla_pkg::ACC_W + 1)'(1) << (rla_pkg::DEC_QF - 1);
   localparam logic [rla_pkg::ACC_W:0] HALF_M1 = HALF - (rla_pkg::ACC_W + 1)'(1);
   localparam logic signed [rla_pkg::RND_W-1:0] SAT_MAX =
      rla_pkg::RND_W'(2 ** (rla_pkg::OUT_W - 1) - 1);
   localparam logic signed [rla_pkg::RND_W-1:0] SAT_MIN =
      rla_pkg::RND_W'(-(2 ** (rla_pkg::OUT_W - 1)));

   logic signed [rla_pkg::SUM_W-1:0] e0, e1, e2;
   logic signed [rla_pkg::SUM_W-1:0] sum_in [rla_pkg::NUM_CH];
   logic signed [rla_pkg::SUM_W-1:0] sum_ff [rla_pkg::NUM_CH];
   logic signed [rla_pkg::ACC_W-1:0] acc_in [rla_pkg::NUM_CH];
   logic signed [rla_pkg::ACC_W-1:0] acc_ff [rla_pkg::NUM_CH];
   logic [rla_pkg::ACC_W:0]          rs     [rla_pkg::NUM_CH];
   logic signed [rla_pkg::RND_W-1:0] rnd    [rla_pkg::NUM_CH];
   logic [rla_pkg::OUT_W-1:0]        out_in [rla_pkg::NUM_CH];
   logic [rla_pkg::OUT_W-1:0]        out_ff [rla_pkg::NUM_CH];

   always_comb begin
      e0 = rla_pkg::SUM_W'(lg[0]);
      e1 = rla_pkg::SUM_W'(lg[1]);
      e2 = rla_pkg::SUM_W'(lg[2]);
      sum_in[0] = e0 + e1 + e2;
      sum_in[1] = e0 + e1 - (e2 <<< 1);
      sum_in[2] = e0 - e1;
   end

   always_comb begin
      acc_in[0] = rla_pkg::ACC_W'(sum_ff[0]) * rla_pkg::ACC_W'(K_L);
      acc_in[1] = rla_pkg::ACC_W'(sum_ff[1]) * rla_pkg::ACC_W'(K_A);
      acc_in[2] = rla_pkg::ACC_W'(sum_ff[2]) * rla_pkg::ACC_W'(K_B);
   end

   // round half away from zero, then clamp to 16 bits
   always_comb begin
      for (int i = 0; i < rla_pkg::NUM_CH; i++) begin
         rs[i]  = {acc_ff[i][rla_pkg::ACC_W-1], acc_ff[i]}
                + (acc_ff[i][rla_pkg::ACC_W-1] ? HALF_M1 : HALF);
         rnd[i] = $signed(rs[i][rla_pkg::ACC_W:rla_pkg::DEC_QF]);
         if (rnd[i] > SAT_MAX) begin
            out_in[i] = SAT_MAX[rla_pkg::OUT_W-1:0];
         end else if (rnd[i] < SAT_MIN) begin
            out_in[i] = SAT_MIN[rla_pkg::OUT_W-1:0];
         end else begin
            out_in[i] = rnd[i][rla_pkg::OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[rla_pkg::ST_SUM]) begin
         sum_ff <= sum_in;
      end
      if (adv[rla_pkg::ST_MUL]) begin
         acc_ff <= acc_in;
      end
      if (adv[rla_pkg::ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign lum   = $signed(out_ff[0]);
   assign alpha = $signed(out_ff[1]);
   assign beta  = $signed(out_ff[2]);

endmodule

`default_nettype wire
